/* rtl/qau_pkg.sv */
// qau_pkg: shared types and constant tables for the quaternion arithmetic unit.
// No dependencies; imported by qau_norm and quaternion_arithmetic_unit_top.

package qau_pkg;

	typedef enum logic [2:0] {
		CMD_MUL  = 3'd0,
		CMD_ROT  = 3'd1,
		CMD_CONJ = 3'd2,
		CMD_NORM = 3'd3,
		CMD_MAT  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic sat;
		logic zero;
	} qau_flags_t;

	typedef struct packed {
		logic [1:0] i0;
		logic [1:0] j0;
		logic [1:0] i1;
		logic [1:0] j1;
		logic       neg;
		logic       sub;
	} mat_term_t;

	localparam logic [1:0] ROW_LAST = 2'd2;

	// Hamilton product: operand index and subtract flag per output component and term
	localparam logic [1:0] HAM_Q [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

	localparam logic HAM_NEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0}
	};

	// rotation matrix entries, row major
	localparam mat_term_t MAT_TAB [9] = '{
		'{2'd0, 2'd0, 2'd1, 2'd1, 1'b0, 1'b1},
		'{2'd1, 2'd2, 2'd0, 2'd3, 1'b1, 1'b0},
		'{2'd0, 2'd2, 2'd1, 2'd3, 1'b0, 1'b0},
		'{2'd0, 2'd3, 2'd1, 2'd2, 1'b0, 1'b0},
		'{2'd0, 2'd0, 2'd2, 2'd2, 1'b0, 1'b1},
		'{2'd2, 2'd3, 2'd0, 2'd1, 1'b1, 1'b0},
		'{2'd1, 2'd3, 2'd0, 2'd2, 1'b1, 1'b0},
		'{2'd0, 2'd1, 2'd2, 2'd3, 1'b0, 1'b0},
		'{2'd0, 2'd0, 2'd3, 2'd3, 1'b0, 1'b1}
	};

endpackage

/* rtl/quaternion_arithmetic_unit_top.sv */
// quaternion_arithmetic_unit_top: pipelined Q-format quaternion multiply, rotate,
// conjugate, normalize and rotation matrix. Depends on qau_pkg and qau_norm.
//
// channel | dir | tdata (low bit up)               | tuser              | tlast
// s_*     | in  | a_w a_x a_y a_z b_w b_x b_y b_z  | command            | -
// m_*     | out | out_w out_x out_y out_z, 0 pad   | saturated zero_norm| last
//
// All commands share one latency, set by the normalize stages (one quotient bit
// per stage). One transaction enters per cycle while s_tready is high; while a
// matrix command's three rows leave, the pipeline is held as under a stall. A
// stall on m_tready freezes the pipeline only while its last stage holds a valid
// transaction. Reset clears valid bits and the matrix row counter only.

module quaternion_arithmetic_unit_top #(
	parameter int COMPONENT_BITS = 16,
	parameter int FRACTION_BITS  = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [8*COMPONENT_BITS-1:0]            s_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z
	input  logic [2:0]                             s_tuser,  // command
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]  m_tdata,  // out_w out_x out_y out_z
	output logic                                   m_tlast,
	output logic [1:0]                             m_tuser   // saturated zero_norm
);
	import qau_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int D  = F + 1;
	localparam int SW = 2*CB + 4;
	localparam int OW = ((4*CB+7)/8)*8;
	localparam logic signed [SW-1:0] CMAX  = SW'((64'sd1 <<< (CB-1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN  = -CMAX - SW'(1);
	localparam logic signed [SW-1:0] RHALF = SW'(64'sd1 <<< (F-1));
	localparam logic signed [SW-1:0] ONE2F = SW'(64'sd1 <<< (2*F));

	typedef struct packed {
		logic          sat;
		logic [CB-1:0] v;
	} rs_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [3:0][CB-1:0] q;
		logic               sat;
		logic               zn;
		logic [8:0][CB-1:0] m;
		logic [2:0]         msat;
	} res_t;

	function automatic rs_t rnd_sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		rs_t                  r;
		t = (v + RHALF) >>> F;
		r.sat = 1'b0;
		if (t > CMAX) begin
			r.v   = CMAX[CB-1:0];
			r.sat = 1'b1;
		end else if (t < CMIN) begin
			r.v   = CMIN[CB-1:0];
			r.sat = 1'b1;
		end else begin
			r.v = t[CB-1:0];
		end
		return r;
	endfunction

	logic adv, take_new, out_last;

	// stage 1: input register
	logic                 v_s1;
	cmd_t                 cmd_s1;
	logic signed [CB-1:0] a_s1 [4];
	logic signed [CB-1:0] b_s1 [4];

	// stage 2: products
	logic                   v_s2;
	cmd_t                   cmd_s2;
	logic signed [CB-1:0]   a_s2 [4];
	logic signed [2*CB-1:0] m1_s2 [4][4];
	logic signed [2*CB-1:0] aa_s2 [4][4];

	// stage 3: first sums
	logic                 v_s3;
	cmd_t                 cmd_s3;
	logic signed [CB-1:0] a_s3 [4];
	logic signed [CB-1:0] p_s3 [4];
	logic                 psat_s3;
	logic [8:0][CB-1:0]   mt_s3;
	logic [2:0]           msat_s3;
	logic [2*CB:0]        s_s3;

	// stage 4: rotate second products
	logic                   v_s4;
	cmd_t                   cmd_s4;
	logic signed [CB-1:0]   a_s4 [4];
	logic signed [CB-1:0]   p_s4 [4];
	logic                   psat_s4;
	logic [8:0][CB-1:0]     mt_s4;
	logic [2:0]             msat_s4;
	logic signed [2*CB-1:0] m2_s4 [4][4];

	// stage 5 and delay to meet normalize
	logic v_s5;
	res_t res_s5;
	logic dv_s [D-2];
	res_t dly_s [D-2];

	logic       out_v_q;
	logic [1:0] row_q;
	res_t       outb_q;

	logic signed [CB-1:0] nres [4];
	qau_flags_t           nflags;

	logic signed [CB-1:0] qo [4];
	logic signed [CB-1:0] p_c [4];
	logic                 psat_c;
	logic [8:0][CB-1:0]   mt_c;
	logic [2:0]           msat_c;
	logic [2*CB:0]        s_c;
	res_t                 res_c;
	res_t                 fin;
	logic                 fin_v;
	res_t                 load_c;

	assign fin      = dly_s[D-3];
	assign fin_v    = dv_s[D-3];
	assign take_new = !out_v_q || (m_tready && out_last);
	assign adv      = !fin_v || take_new;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < D-2; i++)
				dv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_s[0] <= v_s5;
			for (int i = 1; i < D-2; i++)
				dv_s[i] <= dv_s[i-1];
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++)
			qo[j] = (cmd_s1 == CMD_ROT && j == 0) ? '0 : b_s1[j];
	end

	always_comb begin
		logic signed [SW-1:0] acc;
		rs_t                  r;
		psat_c = 1'b0;
		for (int c = 0; c < 4; c++) begin
			acc = '0;
			for (int k = 0; k < 4; k++)
				acc = HAM_NEG[c][k] ? acc - SW'(m1_s2[c][k]) : acc + SW'(m1_s2[c][k]);
			r      = rnd_sat(acc);
			p_c[c] = r.v;
			psat_c = psat_c | r.sat;
		end
		msat_c = '0;
		for (int e = 0; e < 9; e++) begin
			acc = SW'(aa_s2[MAT_TAB[e].i0][MAT_TAB[e].j0]) <<< 1;
			if (MAT_TAB[e].neg)
				acc = acc - (SW'(aa_s2[MAT_TAB[e].i1][MAT_TAB[e].j1]) <<< 1);
			else
				acc = acc + (SW'(aa_s2[MAT_TAB[e].i1][MAT_TAB[e].j1]) <<< 1);
			if (MAT_TAB[e].sub)
				acc = acc - ONE2F;
			r        = rnd_sat(acc);
			mt_c[e]  = r.v;
			msat_c[e/3] = msat_c[e/3] | r.sat;
		end
		s_c = '0;
		for (int i = 0; i < 4; i++)
			s_c = s_c + (2*CB+1)'($unsigned(aa_s2[i][i]));
	end

	always_comb begin
		logic signed [SW-1:0] acc;
		rs_t                  r;
		logic                 rsat;
		res_c      = '0;
		res_c.cmd  = cmd_s4;
		res_c.m    = mt_s4;
		res_c.msat = msat_s4;
		rsat       = 1'b0;
		case (cmd_s4)
			CMD_MUL: begin
				for (int c = 0; c < 4; c++)
					res_c.q[c] = p_s4[c];
				res_c.sat = psat_s4;
			end
			CMD_ROT: begin
				for (int c = 0; c < 4; c++) begin
					acc = '0;
					for (int k = 0; k < 4; k++) begin
						if (HAM_NEG[c][k] ^ (HAM_Q[c][k] != 2'd0))
							acc = acc - SW'(m2_s4[c][k]);
						else
							acc = acc + SW'(m2_s4[c][k]);
					end
					r    = rnd_sat(acc);
					rsat = rsat | r.sat;
					if (c != 0)
						res_c.q[c] = r.v;
				end
				res_c.sat = psat_s4 | rsat;
			end
			CMD_CONJ: begin
				res_c.q[0] = a_s4[0];
				for (int c = 1; c < 4; c++) begin
					if (a_s4[c] == CMIN[CB-1:0]) begin
						res_c.q[c] = CMAX[CB-1:0];
						rsat       = 1'b1;
					end else begin
						res_c.q[c] = CB'(-a_s4[c]);
					end
				end
				res_c.sat = rsat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_t'(s_tuser);
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= s_tdata[i*CB +: CB];
				b_s1[i] <= s_tdata[(4+i)*CB +: CB];
			end

			cmd_s2 <= cmd_s1;
			a_s2   <= a_s1;
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 4; k++) begin
					m1_s2[c][k] <= a_s1[k] * qo[HAM_Q[c][k]];
					aa_s2[c][k] <= a_s1[c] * a_s1[k];
				end
			end

			cmd_s3  <= cmd_s2;
			a_s3    <= a_s2;
			p_s3    <= p_c;
			psat_s3 <= psat_c;
			mt_s3   <= mt_c;
			msat_s3 <= msat_c;
			s_s3    <= s_c;

			cmd_s4  <= cmd_s3;
			a_s4    <= a_s3;
			p_s4    <= p_s3;
			psat_s4 <= psat_s3;
			mt_s4   <= mt_s3;
			msat_s4 <= msat_s3;
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 4; k++)
					m2_s4[c][k] <= p_s3[k] * a_s3[HAM_Q[c][k]];

			res_s5   <= res_c;
			dly_s[0] <= res_s5;
			for (int i = 1; i < D-2; i++)
				dly_s[i] <= dly_s[i-1];
		end
	end

	qau_norm #(
		.CB(CB),
		.F (F)
	) u_norm (
		.clk  (clk),
		.en   (adv),
		.a    (a_s3),
		.s    (s_s3),
		.res  (nres),
		.flags(nflags)
	);

	always_comb begin
		load_c = fin;
		if (fin.cmd == CMD_NORM) begin
			for (int c = 0; c < 4; c++)
				load_c.q[c] = nres[c];
			load_c.sat = nflags.sat;
			load_c.zn  = nflags.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			row_q   <= '0;
		end else if (take_new) begin
			out_v_q <= fin_v && (fin.cmd <= CMD_MAT);
			row_q   <= '0;
		end else if (m_tready && out_v_q) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new)
			outb_q <= load_c;
	end

	always_comb begin
		logic [3:0][CB-1:0] ov;
		logic               osat;
		logic               ozn;
		ov       = outb_q.q;
		osat     = outb_q.sat;
		ozn      = outb_q.zn;
		out_last = 1'b1;
		if (outb_q.cmd == CMD_MAT) begin
			ov[0]    = '0;
			ozn      = 1'b0;
			out_last = (row_q == ROW_LAST);
			case (row_q)
				2'd0: begin
					ov[3:1] = outb_q.m[2:0];
					osat    = outb_q.msat[0];
				end
				2'd1: begin
					ov[3:1] = outb_q.m[5:3];
					osat    = outb_q.msat[1];
				end
				default: begin
					ov[3:1] = outb_q.m[8:6];
					osat    = outb_q.msat[2];
				end
			endcase
		end
		m_tvalid = out_v_q;
		m_tdata  = OW'(ov);
		m_tlast  = out_last;
		m_tuser  = {ozn, osat};
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> row_q != 2'd3)
		else $error("matrix row counter out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> s_tready)
		else $error("input stalled with empty output register");

	a_zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("zero norm reported together with saturation");

	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("matrix rows interrupted");

endmodule

/* rtl/qau_norm.sv */
// qau_norm: pipelined normalize, one quotient bit per stage for four lanes.
// Depends on qau_pkg (qau_flags_t).

module qau_norm #(
	parameter int CB = 16,
	parameter int F  = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CB-1:0] a [4],
	input  logic [2*CB:0]        s,
	output logic signed [CB-1:0] res [4],
	output qau_pkg::qau_flags_t  flags
);
	import qau_pkg::*;

	localparam int D   = F + 1;
	localparam int PW  = 2*CB + 2*F + 5;
	localparam int RW  = F + 1;
	localparam int SSW = 2*CB + 1;
	localparam int VW  = ((CB > F + 2) ? CB : F + 2) + 1;
	localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (CB-1)) - 64'sd1);
	localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

	// r: quotient so far, p = (2r-1)^2*s, q = (2r-1)*s, t = a^2 * 2^(2F+2)
	logic [RW-1:0]        r_s   [D][4];
	logic signed [PW-1:0] p_s   [D][4];
	logic signed [PW-1:0] q_s   [D][4];
	logic signed [PW-1:0] t_s   [D][4];
	logic                 neg_s [D][4];
	logic [SSW-1:0]       sv_s  [D];

	for (genvar k = 0; k < D; k++) begin : g_step
		localparam int B = F - k;
		logic [RW-1:0]        r_i [4];
		logic signed [PW-1:0] p_i [4];
		logic signed [PW-1:0] q_i [4];
		logic signed [PW-1:0] t_i [4];
		logic                 neg_i [4];
		logic [SSW-1:0]       s_i;
		logic [RW-1:0]        r_o [4];
		logic signed [PW-1:0] p_o [4];
		logic signed [PW-1:0] q_o [4];

		if (k == 0) begin : g_head
			logic [CB:0] mag [4];
			always_comb begin
				s_i = s;
				for (int l = 0; l < 4; l++) begin
					mag[l]   = a[l][CB-1] ? (CB+1)'(-$signed({a[l][CB-1], a[l]}))
					                      : (CB+1)'(a[l]);
					r_i[l]   = '0;
					p_i[l]   = $signed(PW'(s));
					q_i[l]   = -$signed(PW'(s));
					t_i[l]   = $signed(PW'(mag[l]) * PW'(mag[l])) <<< (2*F + 2);
					neg_i[l] = a[l][CB-1];
				end
			end
		end else begin : g_body
			always_comb begin
				s_i = sv_s[k-1];
				for (int l = 0; l < 4; l++) begin
					r_i[l]   = r_s[k-1][l];
					p_i[l]   = p_s[k-1][l];
					q_i[l]   = q_s[k-1][l];
					t_i[l]   = t_s[k-1][l];
					neg_i[l] = neg_s[k-1][l];
				end
			end
		end

		always_comb begin
			logic signed [PW-1:0] pc;
			logic                 ok;
			for (int l = 0; l < 4; l++) begin
				pc = p_i[l] + (q_i[l] <<< (B + 2)) + ($signed(PW'(s_i)) <<< (2*B + 2));
				ok = !r_i[l][F] && (pc <= t_i[l]);
				r_o[l] = ok ? (r_i[l] | (RW'(1) << B)) : r_i[l];
				p_o[l] = ok ? pc : p_i[l];
				q_o[l] = ok ? q_i[l] + ($signed(PW'(s_i)) <<< (B + 1)) : q_i[l];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[k] <= s_i;
				for (int l = 0; l < 4; l++) begin
					r_s[k][l]   <= r_o[l];
					p_s[k][l]   <= p_o[l];
					q_s[k][l]   <= q_o[l];
					t_s[k][l]   <= t_i[l];
					neg_s[k][l] <= neg_i[l];
				end
			end
		end
	end

	always_comb begin
		logic signed [VW-1:0] v;
		logic                 zero;
		logic                 any_sat;
		zero    = (sv_s[D-1] == '0);
		any_sat = 1'b0;
		for (int l = 0; l < 4; l++) begin
			v = $signed(VW'(r_s[D-1][l]));
			if (neg_s[D-1][l])
				v = -v;
			if (zero) begin
				res[l] = '0;
			end else if (v > VMAX) begin
				res[l]  = VMAX[CB-1:0];
				any_sat = 1'b1;
			end else if (v < VMIN) begin
				res[l]  = VMIN[CB-1:0];
				any_sat = 1'b1;
			end else begin
				res[l] = v[CB-1:0];
			end
		end
		flags.sat  = any_sat;
		flags.zero = zero;
	end

endmodule
